/* rtl/core/frac_red_pkg.sv */
// Shared types, constants and the control store for the fraction reducer.
package frac_red_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
   localparam int CNT_WIDTH   = $clog2(MAG_WIDTH);
   localparam int PC_WIDTH    = 4;

   localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(MAG_WIDTH - 1);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] numerator;
      logic signed [VALUE_WIDTH-1:0] denominator;
   } frac_red_req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] reduced_numerator;
      logic signed [VALUE_WIDTH-1:0] reduced_denominator;
      logic        [MAG_WIDTH-1:0]   common_divisor;
   } frac_red_rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_STRIP_AB,
      OP_STRIP_A,
      OP_STRIP_B,
      OP_SUB,
      OP_SCALE,
      OP_DIV_STEP,
      OP_NEXT_DIV,
      OP_SAVE_D,
      OP_PASS,
      OP_WRITE
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_NOT_POS,
      C_BOTH_EVEN,
      C_A_EVEN,
      C_B_EVEN,
      C_A_NE_B,
      C_DIV_MORE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type                op;
      cond_type              cond;
      logic [PC_WIDTH-1:0]   target;
   } uop_type;

   // Step addresses. WRITE sits at the top so that falling through wraps to WAIT.
   localparam logic [PC_WIDTH-1:0] PC_WAIT    = 4'd0;
   localparam logic [PC_WIDTH-1:0] PC_CHECK   = 4'd1;
   localparam logic [PC_WIDTH-1:0] PC_TWOS    = 4'd2;
   localparam logic [PC_WIDTH-1:0] PC_STRIP_A = 4'd3;
   localparam logic [PC_WIDTH-1:0] PC_STRIP_B = 4'd4;
   localparam logic [PC_WIDTH-1:0] PC_SUB     = 4'd5;
   localparam logic [PC_WIDTH-1:0] PC_SCALE   = 4'd6;
   localparam logic [PC_WIDTH-1:0] PC_DIV_N   = 4'd7;
   localparam logic [PC_WIDTH-1:0] PC_INIT_D  = 4'd8;
   localparam logic [PC_WIDTH-1:0] PC_DIV_D   = 4'd9;
   localparam logic [PC_WIDTH-1:0] PC_SAVE_D  = 4'd10;
   localparam logic [PC_WIDTH-1:0] PC_PASS    = 4'd11;
   localparam logic [PC_WIDTH-1:0] PC_WRITE   = 4'd15;

   function automatic uop_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      uop_type w;
      case (pc)
         PC_WAIT:    w = '{OP_LOAD,     C_NO_REQ,    PC_WAIT};
         PC_CHECK:   w = '{OP_NOP,      C_NOT_POS,   PC_PASS};
         PC_TWOS:    w = '{OP_STRIP_AB, C_BOTH_EVEN, PC_TWOS};
         PC_STRIP_A: w = '{OP_STRIP_A,  C_A_EVEN,    PC_STRIP_A};
         PC_STRIP_B: w = '{OP_STRIP_B,  C_B_EVEN,    PC_STRIP_B};
         PC_SUB:     w = '{OP_SUB,      C_A_NE_B,    PC_STRIP_B};
         PC_SCALE:   w = '{OP_SCALE,    C_NEVER,     PC_WAIT};
         PC_DIV_N:   w = '{OP_DIV_STEP, C_DIV_MORE,  PC_DIV_N};
         PC_INIT_D:  w = '{OP_NEXT_DIV, C_NEVER,     PC_WAIT};
         PC_DIV_D:   w = '{OP_DIV_STEP, C_DIV_MORE,  PC_DIV_D};
         PC_SAVE_D:  w = '{OP_SAVE_D,   C_ALWAYS,    PC_WRITE};
         PC_PASS:    w = '{OP_PASS,     C_ALWAYS,    PC_WRITE};
         PC_WRITE:   w = '{OP_WRITE,    C_OUT_BUSY,  PC_WRITE};
         default:    w = '{OP_NOP,      C_ALWAYS,    PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/fraction_reducer.sv */
// Fraction reducer: microcoded binary GCD followed by two bit-serial divisions.
//
// Usage: a transaction on the req_ channel carries a signed numerator and
// denominator. One rsp_ transaction follows with both values divided by
// their greatest common divisor and the divisor itself. When either input
// is zero or negative the divisor is 1 and both values pass through.
// A small control store steps a shared datapath: a step counter walks the
// program and conditional jumps close the loops.
// Every transaction passes the check step; a pass-through then goes to
// the pass and write steps. Otherwise the binary GCD loop runs, one shift
// or one subtract per cycle, then the scale step, two restoring divisions
// at one quotient bit per cycle with a hand-over step between them, and
// the save and write steps. One transaction is worked on at a time;
// req_ready is high only while the sequencer waits at its first step, so
// the next transaction is taken only once the sequencer has returned
// from the write step of the previous one.
// The result sits in an output register, so a new transaction is taken
// while an earlier result waits. If the receiver stalls, the sequencer
// holds at its write step until the register frees up.
// Reset returns the step counter to the wait step and drops rsp_valid.
module fraction_reducer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  frac_red_pkg::frac_red_req_type  req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output frac_red_pkg::frac_red_rsp_type  rsp_data
);
   import frac_red_pkg::*;

   logic [PC_WIDTH-1:0]    pc_ff, pc_in;
   uop_type                uop;
   logic                   cond_true;

   logic [VALUE_WIDTH-1:0] n_ff, d_ff;
   logic [MAG_WIDTH-1:0]   a_ff, b_ff, g_ff, quo_ff, rem_ff;
   logic [CNT_WIDTH-1:0]   k_ff, cnt_ff;
   logic [VALUE_WIDTH-1:0] rn_ff, rd_ff;

   logic                   rsp_valid_ff;
   frac_red_rsp_type       rsp_ff;

   logic                   both_pos, out_busy;
   logic                   a_gt_b;
   logic [MAG_WIDTH-1:0]   big, little;
   logic [MAG_WIDTH:0]     trial, trial_diff;
   logic                   fits;

   assign uop = ucode_rom(pc_ff);

   assign both_pos = (n_ff != '0) && !n_ff[VALUE_WIDTH-1] &&
                     (d_ff != '0) && !d_ff[VALUE_WIDTH-1];
   assign out_busy = rsp_valid_ff && !rsp_ready;

   assign a_gt_b = a_ff > b_ff;
   assign big    = a_gt_b ? a_ff : b_ff;
   assign little = a_gt_b ? b_ff : a_ff;

   // One restoring division step: bring down the next dividend bit and
   // subtract the divisor when it fits.
   assign trial      = {rem_ff, quo_ff[MAG_WIDTH-1]};
   assign trial_diff = trial - {1'b0, g_ff};
   assign fits       = trial >= {1'b0, g_ff};

   always_comb begin
      case (uop.cond)
         C_NEVER:     cond_true = 1'b0;
         C_ALWAYS:    cond_true = 1'b1;
         C_NO_REQ:    cond_true = !req_valid;
         C_NOT_POS:   cond_true = !both_pos;
         C_BOTH_EVEN: cond_true = !a_ff[0] && !b_ff[0];
         C_A_EVEN:    cond_true = !a_ff[0];
         C_B_EVEN:    cond_true = !b_ff[0];
         C_A_NE_B:    cond_true = a_ff != b_ff;
         C_DIV_MORE:  cond_true = cnt_ff != DIV_LAST;
         C_OUT_BUSY:  cond_true = out_busy;
         default:     cond_true = 1'b0;
      endcase
      pc_in = cond_true ? uop.target : pc_ff + 1'b1;
   end

   assign req_ready = !reset && uop.op == OP_LOAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      case (uop.op)
         OP_LOAD: begin
            if (req_valid) begin
               n_ff <= req_data.numerator;
               d_ff <= req_data.denominator;
               a_ff <= req_data.numerator[MAG_WIDTH-1:0];
               b_ff <= req_data.denominator[MAG_WIDTH-1:0];
               k_ff <= '0;
            end
         end
         OP_STRIP_AB: begin
            if (!a_ff[0] && !b_ff[0]) begin
               a_ff <= a_ff >> 1;
               b_ff <= b_ff >> 1;
               k_ff <= k_ff + 1'b1;
            end
         end
         OP_STRIP_A: begin
            if (!a_ff[0]) begin
               a_ff <= a_ff >> 1;
            end
         end
         OP_STRIP_B: begin
            if (!b_ff[0]) begin
               b_ff <= b_ff >> 1;
            end
         end
         OP_SUB: begin
            a_ff <= little;
            b_ff <= big - little;
         end
         OP_SCALE: begin
            g_ff   <= a_ff << k_ff;
            quo_ff <= n_ff[MAG_WIDTH-1:0];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff <= fits ? trial_diff[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
            quo_ff <= {quo_ff[MAG_WIDTH-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
         end
         OP_NEXT_DIV: begin
            rn_ff  <= {1'b0, quo_ff};
            quo_ff <= d_ff[MAG_WIDTH-1:0];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_SAVE_D: begin
            rd_ff <= {1'b0, quo_ff};
         end
         OP_PASS: begin
            rn_ff <= n_ff;
            rd_ff <= d_ff;
            g_ff  <= MAG_WIDTH'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (uop.op == OP_WRITE && !out_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (uop.op == OP_WRITE && !out_busy) begin
         rsp_ff.reduced_numerator   <= rn_ff;
         rsp_ff.reduced_denominator <= rd_ff;
         rsp_ff.common_divisor      <= g_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/frac_red_checker.sv */
// Port-level assertions for the fraction reducer and the bind that attaches them.
module frac_red_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  frac_red_pkg::frac_red_req_type  req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  frac_red_pkg::frac_red_rsp_type  rsp_data
);
   import frac_red_pkg::*;

   // A pending result is never withdrawn before the receiver takes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.common_divisor != '0)
      else $error("zero divisor reported");

   // A divisor above one only comes from two positive inputs, so both
   // reduced values must be positive as well.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.common_divisor != MAG_WIDTH'(1) |->
         !rsp_data.reduced_numerator[VALUE_WIDTH-1] &&
         rsp_data.reduced_numerator != '0 &&
         !rsp_data.reduced_denominator[VALUE_WIDTH-1] &&
         rsp_data.reduced_denominator != '0)
      else $error("reduced value not positive");

   // A waiting request transaction stays offered with the same payload.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed before acceptance");

endmodule

bind fraction_reducer frac_red_checker u_frac_red_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/fraction_reducer_tb.sv */
// Self-checking testbench for the fraction reducer: directed corners, then random traffic.
`timescale 1ns / 100ps

module fraction_reducer_tb;
   import frac_red_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 200;
   localparam int MAX_WAIT = 19;

   localparam logic signed [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {MAG_WIDTH{1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {MAG_WIDTH{1'b1}}};

   typedef enum int {
      MIX_ANY,
      MIX_NOT_POS,
      MIX_SHARED,
      MIX_POW2,
      MIX_TINY,
      MIX_WIDE,
      MIX_EQUAL
   } fraction_kind_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   frac_red_req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   frac_red_rsp_type rsp_data;

   frac_red_rsp_type reduced_fractions[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               stall_left = 0;
   bit               steady_flow = 1'b0;

   fraction_reducer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fraction_reducer regression: fail");
         $finish;
      end
   end

   // Divides both values by their greatest common divisor when both are positive.
   function automatic frac_red_rsp_type reduce_fraction(input frac_red_req_type item);
      frac_red_rsp_type       result;
      logic [VALUE_WIDTH-1:0] x;
      logic [VALUE_WIDTH-1:0] y;
      logic [VALUE_WIDTH-1:0] rem;
      logic [VALUE_WIDTH-1:0] num_mag;
      logic [VALUE_WIDTH-1:0] den_mag;
      result.reduced_numerator   = item.numerator;
      result.reduced_denominator = item.denominator;
      result.common_divisor      = MAG_WIDTH'(1);
      if (item.numerator > 0 && item.denominator > 0) begin
         num_mag = item.numerator;
         den_mag = item.denominator;
         x = num_mag;
         y = den_mag;
         while (y != 0) begin
            rem = x % y;
            x = y;
            y = rem;
         end
         result.common_divisor      = x[MAG_WIDTH-1:0];
         result.reduced_numerator   = num_mag / x;
         result.reduced_denominator = den_mag / x;
      end
      return result;
   endfunction

   // Result side: compare each result with the oldest prediction, then stall at random unless steady_flow is set.
   always @(posedge clock) begin
      frac_red_rsp_type want;
      if (reset) begin
         stall_left = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (reduced_fractions.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $realtime, rsp_data);
            mismatch_count++;
         end else begin
            want = reduced_fractions.pop_front();
            if (rsp_data.reduced_numerator !== want.reduced_numerator) begin
               $display("%0t: reduced_numerator expected %0d actual %0d", $realtime,
                        want.reduced_numerator, rsp_data.reduced_numerator);
               mismatch_count++;
            end
            if (rsp_data.reduced_denominator !== want.reduced_denominator) begin
               $display("%0t: reduced_denominator expected %0d actual %0d", $realtime,
                        want.reduced_denominator, rsp_data.reduced_denominator);
               mismatch_count++;
            end
            if (rsp_data.common_divisor !== want.common_divisor) begin
               $display("%0t: common_divisor expected %0d actual %0d", $realtime,
                        want.common_divisor, rsp_data.common_divisor);
               mismatch_count++;
            end
         end
         stall_left = steady_flow ? 0 : $urandom_range(MAX_WAIT, 0);
      end else if (stall_left != 0) begin
         stall_left--;
      end
      rsp_ready <= !reset && stall_left == 0;
   end

   // Sends one fraction after a random gap and records its prediction once accepted.
   task automatic send_fraction(input logic signed [VALUE_WIDTH-1:0] num,
                                input logic signed [VALUE_WIDTH-1:0] den);
      int               gap;
      frac_red_req_type item;
      gap = steady_flow ? 0 : $urandom_range(MAX_WAIT, 0);
      item.numerator   = num;
      item.denominator = den;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      reduced_fractions.push_back(reduce_fraction(item));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reduced_fractions.size() != 0) @(posedge clock);
   endtask

   function automatic fraction_kind_type pick_kind();
      int roll;
      roll = $urandom_range(15, 0);
      if (roll < 2)       return MIX_ANY;
      else if (roll < 4)  return MIX_NOT_POS;
      else if (roll < 9)  return MIX_SHARED;
      else if (roll < 10) return MIX_POW2;
      else if (roll < 12) return MIX_TINY;
      else if (roll < 14) return MIX_WIDE;
      else                return MIX_EQUAL;
   endfunction

   // Most fractions are positive, and the largest share carries a common factor so that the reduction has work to do.
   task automatic send_random_fraction();
      logic [VALUE_WIDTH-1:0] num;
      logic [VALUE_WIDTH-1:0] den;
      logic [VALUE_WIDTH-1:0] scale;
      logic [VALUE_WIDTH-1:0] span;
      case (pick_kind())
         MIX_ANY: begin
            num = $urandom;
            den = $urandom;
         end
         MIX_NOT_POS: begin
            num = $urandom;
            den = $urandom_range(1, 0) ? '0 : ($urandom | MOST_NEG);
            if ($urandom_range(1, 0)) {num, den} = {den, num};
         end
         MIX_SHARED: begin
            scale = $urandom >> $urandom_range(31, 1);
            if (scale == 0) scale = 1;
            span = MOST_POS / scale;
            num = $urandom_range(span, 1) * scale;
            den = $urandom_range(span, 1) * scale;
         end
         MIX_POW2: begin
            num = 32'd1 << $urandom_range(MAG_WIDTH - 1, 0);
            den = 32'd1 << $urandom_range(MAG_WIDTH - 1, 0);
            if ($urandom_range(1, 0)) num = num * 3 / 2 + 1;
         end
         MIX_TINY: begin
            num = $urandom_range(64, 1);
            den = $urandom_range(64, 1);
         end
         MIX_WIDE: begin
            num = $urandom_range(MOST_POS, 1);
            den = $urandom_range(MOST_POS, 1);
         end
         default: begin
            num = $urandom_range(MOST_POS, 1);
            den = num;
         end
      endcase
      send_fraction(num, den);
   endtask

   task automatic test_corner_fractions();
      send_fraction(0, 0);
      send_fraction(0, 5);
      send_fraction(5, 0);
      send_fraction(-1, 4);
      send_fraction(4, -1);
      send_fraction(-6, -4);
      send_fraction(MOST_NEG, MOST_NEG);
      send_fraction(MOST_NEG, 6);
      send_fraction(6, MOST_NEG);
      send_fraction(MOST_POS, MOST_POS);
      send_fraction(MOST_POS, 1);
      send_fraction(1, MOST_POS);
      send_fraction(MOST_POS, MOST_POS - 1);
      send_fraction(MOST_POS, -1);
      send_fraction(-1, -1);
      send_fraction(1, 1);
      send_fraction(12, 18);
      send_fraction(17, 31);
      send_fraction(1000, 1000);
      send_fraction(32'h4000_0000, 32'h2000_0000);
      send_fraction(32'h4000_0000, 32'h4000_0000);
      send_fraction(3 << 20, 9 << 10);
      send_fraction(32'h5555_5555, 32'h2AAA_AAAA);
      send_fraction(MOST_POS - 1, 2);
   endtask

   // Neither side idles here, so transactions follow each other as fast as the block allows.
   task automatic test_back_to_back();
      steady_flow = 1'b1;
      repeat (60) send_random_fraction();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_fractions();
      repeat (500) send_random_fraction();
   endtask

   task automatic test_drain_pause();
      repeat (4) begin
         repeat (15) send_random_fraction();
         wait_for_drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_fractions();
      test_back_to_back();
      test_random_fractions();
      test_drain_pause();
      req_valid <= 1'b0;
      while (reduced_fractions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fraction_reducer regression: pass");
      end else begin
         $display("fraction_reducer regression: fail");
      end
      $finish;
   end

endmodule
